@@ rtl/cbs_pkg.sv @@
// Package for the cartridge bank switch with scanline interrupt counter.
// Holds the word types, action and command codes and counter constants.
// Used by cartridge_bank_switch_scanline_irq and by the bench; depends on nothing.
package cbs_pkg;

    localparam int CTR_W = 20;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CTR_W-1:0] DOTS_PER_LINE = 20'd341;
    localparam logic [CTR_W-1:0] RELOAD_BASE = 20'd196605;

    localparam logic [15:0] ADDR_CMD = 16'h8000;
    localparam logic [15:0] ADDR_PARAM = 16'ha000;

    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_RAM_WRITE = 3'd1;
    localparam logic [2:0] ACT_CHR_SET = 3'd2;
    localparam logic [2:0] ACT_PRG_SET = 3'd3;
    localparam logic [2:0] ACT_MIRROR_SET = 3'd4;

    localparam logic [3:0] CMD_PRG_RAM = 4'd8;
    localparam logic [3:0] CMD_PRG_8000 = 4'd9;
    localparam logic [3:0] CMD_PRG_A000 = 4'd10;
    localparam logic [3:0] CMD_PRG_C000 = 4'd11;
    localparam logic [3:0] CMD_MIRROR = 4'd12;
    localparam logic [3:0] CMD_IRQ_CTRL = 4'd13;
    localparam logic [3:0] CMD_CTR_LOW = 4'd14;
    localparam logic [3:0] CMD_CTR_HIGH = 4'd15;

    localparam logic REG_CHR_MASK = 1'b0;
    localparam logic REG_PRG_MASK = 1'b1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  slot;
        logic [7:0]  page;
        logic [14:0] ram_address;
        logic [7:0]  ram_data;
        logic        irq_line;
        logic        ram_enabled;
    } out_word_t;

endpackage

@@ rtl/cartridge_bank_switch_scanline_irq.sv @@
// Top level of the cartridge bank switch with scanline interrupt counter.
// Depends on cbs_pkg for word types, codes and counter constants.
//
//   Channel  Ports                          Carries
//   s_       s_valid, s_ready, s_data       CPU write or scanline tick word
//   m_       m_valid, m_ready, m_data       one action word per input word
//   APB      psel .. prdata, pready         CHR and PRG page masks
//
// A word is captured in an input register; once the output register is free or
// being taken, the decode and the counter arithmetic update the mapper state and
// load the output register, which raises m_valid.
// One word per cycle is sustained while m_ready stays high.
// A stalled output holds its word while one more word waits in the input
// register. Reset is synchronous on aresetn and clears all mapper state.
module cartridge_bank_switch_scanline_irq (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  cbs_pkg::in_word_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output cbs_pkg::out_word_t       m_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [cbs_pkg::PADDR_W-1:0] paddr,
    input  logic [cbs_pkg::PDATA_W-1:0] pwdata,
    output logic [cbs_pkg::PDATA_W-1:0] prdata,
    output logic                     pready
);
    import cbs_pkg::*;

    logic [7:0]       chr_mask_reg;
    logic [5:0]       prg_mask_reg;
    logic [3:0]       command_reg;
    logic [3:0]       command_next;
    logic             ram_en_reg;
    logic             ram_en_next;
    logic             irq_en_reg;
    logic             irq_en_next;
    logic             count_en_reg;
    logic             count_en_next;
    logic [CTR_W-1:0] counter_reg;
    logic [CTR_W-1:0] counter_next;
    logic             irq_reg;
    logic             irq_next;

    logic             mid_valid_reg;
    in_word_t         mid_reg;
    logic             out_valid_reg;
    out_word_t        out_reg;
    out_word_t        out_next;

    logic             out_load;
    logic             cfg_write;
    logic [CTR_W-1:0] ctr_less;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_CHR_MASK: prdata = {24'd0, chr_mask_reg};
            REG_PRG_MASK: prdata = {26'd0, prg_mask_reg};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chr_mask_reg <= 8'hff;
            prg_mask_reg <= 6'h3f;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_CHR_MASK: chr_mask_reg <= pwdata[7:0];
                REG_PRG_MASK: prg_mask_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    assign out_load = mid_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !mid_valid_reg || out_load;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    assign ctr_less = counter_reg - DOTS_PER_LINE;

    always_comb begin
        command_next = command_reg;
        ram_en_next = ram_en_reg;
        irq_en_next = irq_en_reg;
        count_en_next = count_en_reg;
        counter_next = counter_reg;
        irq_next = irq_reg;
        out_next = '0;

        if (mid_reg.kind == KIND_TICK) begin
            if (count_en_reg) begin
                if (counter_reg <= DOTS_PER_LINE) begin
                    counter_next = RELOAD_BASE + ctr_less;
                    if (irq_en_reg) begin
                        irq_next = 1'b1;
                    end
                end else begin
                    counter_next = ctr_less;
                end
            end
        end else if (!mid_reg.address[15]) begin
            if (ram_en_reg) begin
                out_next.action = ACT_RAM_WRITE;
                out_next.ram_address = mid_reg.address[14:0];
                out_next.ram_data = mid_reg.value;
            end
        end else if (mid_reg.address == ADDR_CMD) begin
            command_next = mid_reg.value[3:0];
        end else if (mid_reg.address == ADDR_PARAM) begin
            case (command_reg)
                CMD_PRG_RAM: begin
                    if (!mid_reg.value[6]) begin
                        out_next.action = ACT_PRG_SET;
                        out_next.page = {2'd0, mid_reg.value[5:0] & prg_mask_reg};
                    end
                    ram_en_next = mid_reg.value[7];
                end
                CMD_PRG_8000, CMD_PRG_A000, CMD_PRG_C000: begin
                    out_next.action = ACT_PRG_SET;
                    out_next.slot = {1'b0, command_reg[1:0]};
                    out_next.page = {2'd0, mid_reg.value[5:0] & prg_mask_reg};
                end
                CMD_MIRROR: begin
                    out_next.action = ACT_MIRROR_SET;
                    out_next.page = {6'd0, mid_reg.value[1:0]};
                end
                CMD_IRQ_CTRL: begin
                    count_en_next = mid_reg.value[0];
                    irq_en_next = mid_reg.value[7] && mid_reg.value[0];
                    irq_next = 1'b0;
                    if (mid_reg.value[0]) begin
                        counter_next = counter_reg + {counter_reg[CTR_W-2:0], 1'b0};
                    end
                end
                CMD_CTR_LOW: begin
                    counter_next = {4'd0, counter_reg[15:8], mid_reg.value};
                end
                CMD_CTR_HIGH: begin
                    counter_next = {4'd0, mid_reg.value, counter_reg[7:0]};
                end
                default: begin
                    out_next.action = ACT_CHR_SET;
                    out_next.slot = command_reg[2:0];
                    out_next.page = mid_reg.value & chr_mask_reg;
                end
            endcase
        end

        out_next.irq_line = irq_next;
        out_next.ram_enabled = ram_en_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            command_reg <= '0;
            ram_en_reg <= 1'b0;
            irq_en_reg <= 1'b0;
            count_en_reg <= 1'b0;
            counter_reg <= '0;
            irq_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                mid_valid_reg <= 1'b1;
            end else if (out_load) begin
                mid_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
                command_reg <= command_next;
                ram_en_reg <= ram_en_next;
                irq_en_reg <= irq_en_next;
                count_en_reg <= count_en_next;
                counter_reg <= counter_next;
                irq_reg <= irq_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mid_reg <= s_data;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    a_irq_en_needs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        irq_en_reg |-> count_en_reg)
        else $error("IRQ enable set while counting is disabled.");

    a_unused_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.action != ACT_RAM_WRITE) |->
            (m_data.ram_address == 15'd0 && m_data.ram_data == 8'd0))
        else $error("Save RAM fields set on a word that is not a RAM write.");

    a_none_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.action == ACT_NONE) |->
            (m_data.slot == 3'd0 && m_data.page == 8'd0))
        else $error("Slot or page set on a word with no action.");

    a_mid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (mid_valid_reg && !out_load) |=> (mid_valid_reg && $stable(mid_reg)))
        else $error("Waiting input word lost or changed while the output stalled.");

    a_state_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_load |=> ($stable(counter_reg) && $stable(command_reg)))
        else $error("Mapper state changed without a word moving to the output.");

endmodule

@@ bench/mapper_action_checker.sv @@
// Checker for the cartridge bank switch: predicts one action word per input word
// and compares the result channel with it, field by field. Follows mask writes on APB.
// Depends on cbs_pkg for the word types, action and command codes.
`timescale 1ns / 100ps
module mapper_action_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  cbs_pkg::in_word_t           s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  cbs_pkg::out_word_t          m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [cbs_pkg::PADDR_W-1:0] paddr,
    input  logic [cbs_pkg::PDATA_W-1:0] pwdata,
    output int                          mismatches,
    output int                          awaited
);
    import cbs_pkg::*;

    localparam int OUT_W = $bits(out_word_t);

    logic [7:0]       chr_mask;
    logic [5:0]       prg_mask;
    logic [3:0]       cmd_latch;
    logic             ram_on;
    logic             irq_on;
    logic             count_on;
    logic             irq_out;
    logic [CTR_W-1:0] dots_left;
    out_word_t        expected_actions[$];

    initial begin
        mismatches = 0;
        awaited = 0;
    end

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want_v,
                                   input logic [OUT_W-1:0] got_v);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
        mismatches++;
    endtask

    function automatic out_word_t step_mapper(input in_word_t w);
        out_word_t r;
        r = '0;
        if (w.kind == KIND_TICK) begin
            if (count_on) begin
                if (dots_left <= DOTS_PER_LINE) begin
                    dots_left = RELOAD_BASE + dots_left - DOTS_PER_LINE;
                    if (irq_on) begin
                        irq_out = 1'b1;
                    end
                end else begin
                    dots_left = dots_left - DOTS_PER_LINE;
                end
            end
        end else if (w.address < ADDR_CMD) begin
            if (ram_on) begin
                r.action = ACT_RAM_WRITE;
                r.ram_address = w.address[14:0];
                r.ram_data = w.value;
            end
        end else if (w.address == ADDR_CMD) begin
            cmd_latch = w.value[3:0];
        end else if (w.address == ADDR_PARAM) begin
            case (cmd_latch)
                CMD_PRG_RAM: begin
                    if (!w.value[6]) begin
                        r.action = ACT_PRG_SET;
                        r.page = {2'b00, w.value[5:0] & prg_mask};
                    end
                    ram_on = w.value[7];
                end
                CMD_PRG_8000, CMD_PRG_A000, CMD_PRG_C000: begin
                    r.action = ACT_PRG_SET;
                    r.slot = 3'(cmd_latch - CMD_PRG_RAM);
                    r.page = {2'b00, w.value[5:0] & prg_mask};
                end
                CMD_MIRROR: begin
                    r.action = ACT_MIRROR_SET;
                    r.page = {6'b0, w.value[1:0]};
                end
                CMD_IRQ_CTRL: begin
                    count_on = w.value[0];
                    irq_on = w.value[7] & w.value[0];
                    irq_out = 1'b0;
                    if (count_on) begin
                        dots_left = CTR_W'(dots_left * 3);
                    end
                end
                CMD_CTR_LOW: begin
                    dots_left = {4'b0, dots_left[15:8], w.value};
                end
                CMD_CTR_HIGH: begin
                    dots_left = {4'b0, w.value, dots_left[7:0]};
                end
                default: begin
                    r.action = ACT_CHR_SET;
                    r.slot = cmd_latch[2:0];
                    r.page = w.value & chr_mask;
                end
            endcase
        end
        r.irq_line = irq_out;
        r.ram_enabled = ram_on;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            chr_mask = 8'hff;
            prg_mask = 6'h3f;
            cmd_latch = '0;
            ram_on = 1'b0;
            irq_on = 1'b0;
            count_on = 1'b0;
            irq_out = 1'b0;
            dots_left = '0;
            expected_actions.delete();
            awaited <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[PADDR_W-1:2] == REG_CHR_MASK) begin
                    chr_mask = pwdata[7:0];
                end else if (paddr[PADDR_W-1:2] == REG_PRG_MASK) begin
                    prg_mask = pwdata[5:0];
                end
            end
            if (m_valid && m_ready) begin
                if (expected_actions.size() == 0) begin
                    report_mismatch("unexpected word", '0, m_data);
                end else begin
                    want = expected_actions.pop_front();
                    if (m_data.action !== want.action)
                        report_mismatch("action", OUT_W'(want.action),
                                        OUT_W'(m_data.action));
                    if (m_data.slot !== want.slot)
                        report_mismatch("slot", OUT_W'(want.slot), OUT_W'(m_data.slot));
                    if (m_data.page !== want.page)
                        report_mismatch("page", OUT_W'(want.page), OUT_W'(m_data.page));
                    if (m_data.ram_address !== want.ram_address)
                        report_mismatch("ram_address", OUT_W'(want.ram_address),
                                        OUT_W'(m_data.ram_address));
                    if (m_data.ram_data !== want.ram_data)
                        report_mismatch("ram_data", OUT_W'(want.ram_data),
                                        OUT_W'(m_data.ram_data));
                    if (m_data.irq_line !== want.irq_line)
                        report_mismatch("irq_line", OUT_W'(want.irq_line),
                                        OUT_W'(m_data.irq_line));
                    if (m_data.ram_enabled !== want.ram_enabled)
                        report_mismatch("ram_enabled", OUT_W'(want.ram_enabled),
                                        OUT_W'(m_data.ram_enabled));
                end
            end
            if (s_valid && s_ready) begin
                expected_actions.push_back(step_mapper(s_data));
            end
            awaited <= expected_actions.size();
        end
    end

endmodule

@@ bench/cartridge_bank_switch_scanline_irq_test.sv @@
// Top of the cartridge bank switch bench: drives CPU writes, scanline ticks and
// mask writes, varies idling on both channels and gives the verdict.
// Depends on cbs_pkg, the block under test and mapper_action_checker.
`timescale 1ns / 100ps
module cartridge_bank_switch_scanline_irq_test;
    import cbs_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int SEGMENT_WORDS = 185;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_word_t           s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_word_t          m_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 mismatches;
    int                 awaited;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int                 tx_run = 0;
    int                 rx_run = 0;
    int                 quiet_cycles = 0;
    int                 words_sent = 0;

    cartridge_bank_switch_scanline_irq u_top (.*);

    mapper_action_checker u_check (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        if (rx_run > 0) begin
            rx_run <= rx_run - 1;
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 63) == 0) begin
            rx_run <= $urandom_range(10, 40);
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic kind, input logic [15:0] addr, input logic [7:0] val);
        while (tx_run == 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        if (tx_run > 0) begin
            tx_run--;
        end else if ($urandom_range(0, 63) == 0) begin
            tx_run = $urandom_range(10, 40);
        end
        s_valid <= 1'b1;
        s_data <= '{kind, addr, val};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic cpu_write(input logic [15:0] addr, input logic [7:0] val);
        send_word(KIND_WRITE, addr, val);
    endtask

    task automatic line_ticks(input int count);
        repeat (count) send_word(KIND_TICK, 16'($urandom), 8'($urandom));
    endtask

    task automatic run_command(input logic [3:0] cmd, input logic [7:0] val);
        cpu_write(ADDR_CMD, {4'($urandom), cmd});
        cpu_write(ADDR_PARAM, val);
    endtask

    task automatic wait_drained;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited != 0) @(posedge aclk);
    endtask

    task automatic write_mask(input logic idx, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_masks(input logic [7:0] chr, input logic [5:0] prg);
        wait_drained();
        write_mask(REG_CHR_MASK, PDATA_W'(chr));
        write_mask(REG_PRG_MASK, PDATA_W'(prg));
    endtask

    task automatic random_traffic;
        int pick;
        logic [3:0] cmd;
        logic [7:0] val;
        pick = $urandom_range(0, 99);
        cmd = 4'($urandom);
        val = 8'($urandom);
        if (pick < 30) begin
            if (cmd == CMD_IRQ_CTRL && $urandom_range(0, 4) != 0) begin
                val[0] = 1'b1;
            end else if (cmd == CMD_CTR_HIGH && $urandom_range(0, 1) == 0) begin
                val = 8'($urandom_range(0, 3));
            end
            run_command(cmd, val);
        end else if (pick < 42) begin
            cpu_write(ADDR_PARAM, val);
        end else if (pick < 57) begin
            cpu_write({1'b0, 15'($urandom)}, val);
        end else if (pick < 65) begin
            run_command(CMD_CTR_LOW, val);
            run_command(CMD_CTR_HIGH, 8'($urandom_range(0, 3)));
            run_command(CMD_IRQ_CTRL, {1'($urandom), 6'($urandom), 1'b1});
            line_ticks($urandom_range(2, 12));
        end else if (pick < 90) begin
            line_ticks($urandom_range(1, 4));
        end else begin
            send_word(1'($urandom), 16'($urandom), val);
        end
    endtask

    initial begin
        int seg;
        int target;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 18;
        rx_idle_pct <= 86;
        set_masks(8'hff, 6'h3f);

        line_ticks(1);
        cpu_write(16'h7fff, 8'hff);
        cpu_write(ADDR_CMD, {4'hf, CMD_PRG_RAM});
        cpu_write(ADDR_PARAM, 8'hc0);
        cpu_write(16'h0000, 8'h00);
        cpu_write(16'h7fff, 8'hff);
        cpu_write(ADDR_PARAM, 8'h3f);
        run_command(4'd7, 8'hff);
        run_command(CMD_PRG_C000, 8'hff);
        run_command(CMD_MIRROR, 8'hff);
        run_command(CMD_IRQ_CTRL, 8'h81);
        line_ticks(1);
        run_command(CMD_CTR_LOW, 8'h55);
        run_command(CMD_CTR_HIGH, 8'h01);
        line_ticks(1);
        cpu_write(16'hffff, 8'hff);
        cpu_write(16'ha001, 8'h00);

        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                0: set_masks(8'h00, 6'h00);
                1: set_masks(8'($urandom), 6'($urandom));
                2: set_masks(8'hff, 6'h3f);
                3: set_masks(8'h55, 6'h2a);
                4: set_masks(8'($urandom), 6'($urandom));
                default: set_masks(8'haa, 6'h15);
            endcase
            if (seg == 2) begin
                tx_idle_pct = 86;
                rx_idle_pct <= 18;
            end else if (seg == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            target = words_sent + SEGMENT_WORDS;
            while (words_sent < target) random_traffic();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && awaited == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/cbs_pkg.sv
rtl/cartridge_bank_switch_scanline_irq.sv
bench/mapper_action_checker.sv
bench/cartridge_bank_switch_scanline_irq_test.sv
